[design/vtfa_pkg.sv]
// package: types, constants and helpers shared by the fair arbiter
`timescale 1ns / 1ps
`default_nettype none
package vtfa_pkg;
  localparam int NUM_CONTEXTS_DEF = 16;
  localparam int FIFO_DEPTH_DEF = 16;
  localparam int COST_SHIFT_DEF = 10;
  localparam int SCALE_W = 7;
  localparam int SCALE_MIN = 1;
  localparam int SCALE_MAX = 100;
  localparam int VT_W = 64;
  localparam int STAMP_W = 32;
  localparam int CHARGE_W = 17;
  localparam int CTX_W = 4;
  localparam int BUSY_W = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic CFG_READ_SCALE = 1'b0;
  localparam logic CFG_WRITE_SCALE = 1'b1;
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [3:0] context_id;
    logic       is_write;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        granted;
    logic [3:0]  granted_context;
    logic        granted_is_write;
    logic [16:0] charge;
    logic [4:0]  busy_contexts;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // capture input beat
    logic ins_prep;  // read context state for insert
    logic ins_do;    // perform insert
    logic scan_init; // start least-vtime scan
    logic scan_step; // compare one context
    logic dis_do;    // pop and charge the winner
    logic div_start;
    logic div_step;
    logic div_done;
    logic min_init;
    logic res_ok;    // load result register
  } cmd_t;

  typedef struct packed {
    logic is_dispatch;
    logic full;
    logic was_busy;
    logic scan_last;
    logic found;
    logic need_div;
    logic div_last;
  } stat_t;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    if (v < SCALE_W'(SCALE_MIN)) return SCALE_W'(SCALE_MIN);
    if (v > SCALE_W'(SCALE_MAX)) return SCALE_W'(SCALE_MAX);
    return v;
  endfunction

  function automatic logic [VT_W-1:0] later_of(input logic [VT_W-1:0] fl,
                                               input logic [VT_W-1:0] v);
    logic [VT_W-1:0] d;
    d = v - fl;
    if (d != '0 && !d[VT_W-1]) return v;
    return fl;
  endfunction
endpackage
`default_nettype wire

[design/vtfa_ram.sv]
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vtfa_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[design/vtfa_ctrl.sv]
// controller state machine sequencing insert and dispatch
`timescale 1ns / 1ps
`default_nettype none
module vtfa_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire vtfa_pkg::stat_t st,
  output vtfa_pkg::cmd_t     cmd
);
  import vtfa_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_INS = 4'd2,
                         S_SCAN = 4'd3, S_RD = 4'd4, S_DIS = 4'd5,
                         S_DIV = 4'd6, S_FIN = 4'd7, S_MIN = 4'd8,
                         S_MINS = 4'd9, S_OUT = 4'd10, S_INSP = 4'd11;
  logic [3:0] state, state_next;
  logic       ovalid, ovalid_next;

  assign out_valid = ovalid;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ovalid_next = ovalid && out_stall;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin cmd.load = 1'b1; state_next = S_DEC; end
      S_DEC: begin
        if (st.is_dispatch) begin cmd.scan_init = 1'b1; state_next = S_SCAN; end
        else begin cmd.ins_prep = 1'b1; state_next = S_INSP; end
      end
      S_INSP: state_next = S_INS;
      S_INS: begin
        cmd.ins_do = 1'b1;
        if (!st.full && !st.was_busy) begin
          cmd.scan_init = 1'b1; cmd.min_init = 1'b1; state_next = S_MINS;
        end else state_next = S_OUT;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.scan_last) state_next = S_RD;
      end
      S_RD: state_next = st.found ? S_DIS : S_OUT;
      S_DIS: begin
        cmd.div_start = 1'b1;
        state_next = st.need_div ? S_DIV : S_FIN;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.div_done = 1'b1; cmd.dis_do = 1'b1;
        cmd.scan_init = 1'b1; cmd.min_init = 1'b1; state_next = S_MINS;
      end
      S_MINS: begin
        cmd.scan_step = 1'b1; cmd.min_init = 1'b1;
        if (st.scan_last) state_next = S_MIN;
      end
      S_MIN: state_next = S_OUT;
      S_OUT: if (!ovalid || !out_stall) begin
        cmd.res_ok = 1'b1; ovalid_next = 1'b1; state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ovalid <= 1'b0;
    end else begin
      state <= state_next;
      ovalid <= ovalid_next;
    end
  end
endmodule
`default_nettype wire

[design/vtfa_dp.sv]
// datapath: context table, direction ram, scan, cost divider, result register
`timescale 1ns / 1ps
`default_nettype none
module vtfa_dp #(
  parameter int NUM_CONTEXTS = vtfa_pkg::NUM_CONTEXTS_DEF,
  parameter int FIFO_DEPTH = vtfa_pkg::FIFO_DEPTH_DEF,
  parameter int COST_SHIFT = vtfa_pkg::COST_SHIFT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire vtfa_pkg::in_item_t  in_data,
  input  wire logic                cfg_valid,
  input  wire logic [vtfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vtfa_pkg::SCALE_W-1:0]   cfg_data,
  input  wire vtfa_pkg::cmd_t      cmd,
  output vtfa_pkg::stat_t          st,
  output vtfa_pkg::out_item_t      out_data
);
  import vtfa_pkg::*;
  localparam int CW = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int FW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int PW = $clog2(FIFO_DEPTH + 1);
  localparam int NW = $clog2(NUM_CONTEXTS + 1);
  localparam int NUM_W = COST_SHIFT + 2 * SCALE_W; // dividend width
  localparam int DCW = $clog2(NUM_W + 1);
  localparam int IDS = 1 << CTX_W;

  logic [SCALE_W-1:0] rd_wt, wr_wt;
  logic [VT_W-1:0]    vtime [NUM_CONTEXTS];
  logic [PW-1:0]      pending [NUM_CONTEXTS];
  logic               busy [NUM_CONTEXTS];
  logic [STAMP_W-1:0] stamp [NUM_CONTEXTS];
  logic [FW-1:0]      head [NUM_CONTEXTS];
  logic [FW-1:0]      tail [NUM_CONTEXTS];
  logic [VT_W-1:0]    gmin;
  logic [NW-1:0]      busy_count;
  logic [STAMP_W-1:0] next_stamp;

  in_item_t    item;
  logic [CW-1:0] cur;     // insert context or scan winner
  logic [CW-1:0] scan_i;
  logic          scan_found;
  logic [VT_W-1:0] best_vt;
  logic [STAMP_W-1:0] best_st;
  logic          ins_full, ins_busy;
  logic          grant_ok, grant_w;
  logic [NUM_W-1:0] rem, quo, dvd;
  logic [DCW-1:0]   dcnt;
  logic [VT_W-1:0]  cost, cost_now;
  logic [CW+FW-1:0] ram_waddr, ram_raddr;
  logic             ram_we, ram_rd;
  out_item_t        res;

  // context index from 4-bit id, modulo the context count
  logic [CW-1:0] ctx_map [IDS];
  logic [CW-1:0] in_ctx;
  for (genvar g = 0; g < IDS; g++) begin : g_ctx_map
    assign ctx_map[g] = CW'(g % NUM_CONTEXTS);
  end
  assign in_ctx = ctx_map[item.context_id];

  assign ram_we = cmd.ins_do && !ins_full;
  assign ram_waddr = {cur, tail[cur]};
  assign ram_raddr = {cur, head[cur]};

  vtfa_ram #(.WIDTH(1), .DEPTH(1 << (CW + FW))) u_fifo (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(item.is_write),
    .raddr(ram_raddr), .rdata(ram_rd)
  );

  // one scan comparison
  logic better;
  logic [STAMP_W-1:0] sdiff;
  assign sdiff = stamp[scan_i] - best_st;
  always_comb begin
    better = 1'b0;
    if (busy[scan_i]) begin
      if (!scan_found || vtime[scan_i] < best_vt) better = 1'b1;
      else if (vtime[scan_i] == best_vt && sdiff[STAMP_W-1]) better = 1'b1;
    end
  end

  assign st.is_dispatch = item.req_type == REQ_DISPATCH;
  assign st.full = ins_full;
  assign st.was_busy = ins_busy;
  assign st.scan_last = scan_i == CW'(NUM_CONTEXTS - 1);
  assign st.found = scan_found;
  assign st.need_div = ram_rd;
  assign st.div_last = dcnt == DCW'(1);
  assign out_data = res;

  // cost of the granted request, quotient is final once the divider is done
  assign cost_now = grant_w ? VT_W'(quo) : (VT_W'(1) << COST_SHIFT);

  logic [NUM_W:0] trial;
  assign trial = {rem[NUM_W-2:0], dvd[NUM_W-1]} - (NUM_W+1)'(rd_wt);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_wt <= SCALE_W'(1);
      wr_wt <= SCALE_W'(1);
      gmin <= '0;
      busy_count <= '0;
      next_stamp <= '0;
      for (int i = 0; i < NUM_CONTEXTS; i++) begin
        vtime[i] <= '0; pending[i] <= '0; busy[i] <= 1'b0;
        stamp[i] <= '0; head[i] <= '0; tail[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        if (cfg_index == CFG_READ_SCALE) rd_wt <= clamp_scale(cfg_data);
        else wr_wt <= clamp_scale(cfg_data);
      end
      if (cmd.ins_do && !ins_full) begin
        tail[cur] <= (tail[cur] == FW'(FIFO_DEPTH - 1)) ? '0 : tail[cur] + FW'(1);
        pending[cur] <= pending[cur] + PW'(1);
        if (!ins_busy) begin
          busy[cur] <= 1'b1;
          busy_count <= busy_count + NW'(1);
          vtime[cur] <= later_of(gmin, vtime[cur]);
          stamp[cur] <= next_stamp;
          next_stamp <= next_stamp + STAMP_W'(1);
        end
      end
      if (cmd.dis_do) begin
        head[cur] <= (head[cur] == FW'(FIFO_DEPTH - 1)) ? '0 : head[cur] + FW'(1);
        pending[cur] <= pending[cur] - PW'(1);
        vtime[cur] <= vtime[cur] + cost_now;
        if (pending[cur] == PW'(1)) begin
          busy[cur] <= 1'b0;
          busy_count <= busy_count - NW'(1);
        end else begin
          stamp[cur] <= next_stamp;
          next_stamp <= next_stamp + STAMP_W'(1);
        end
      end
      // minimum refresh on the last step of the minimum scan
      if (cmd.min_init && !cmd.scan_init && st.scan_last && (scan_found || better))
        gmin <= later_of(gmin, better ? vtime[scan_i] : best_vt);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_data;
    if (cmd.ins_prep) begin
      cur <= in_ctx;
    end
    if (cmd.ins_prep || cmd.ins_do) begin
      ins_full <= pending[in_ctx] >= PW'(FIFO_DEPTH);
      ins_busy <= busy[in_ctx];
    end
    if (cmd.load) grant_ok <= 1'b0;
    else if (cmd.div_start) grant_ok <= 1'b1;
    if (cmd.scan_init) begin
      scan_i <= '0;
      scan_found <= 1'b0;
    end else if (cmd.scan_step) begin
      if (better) begin
        scan_found <= 1'b1;
        best_vt <= vtime[scan_i];
        best_st <= stamp[scan_i];
        if (!cmd.min_init) cur <= scan_i;
      end
      if (!st.scan_last) scan_i <= scan_i + CW'(1);
    end
    if (cmd.div_start) begin
      grant_w <= ram_rd;
      dvd <= NUM_W'(wr_wt) << COST_SHIFT;
      rem <= '0;
      quo <= '0;
      dcnt <= DCW'(NUM_W);
      cost <= VT_W'(1) << COST_SHIFT;
    end else if (cmd.div_step) begin
      // restoring division, one quotient bit a cycle
      dvd <= dvd << 1;
      dcnt <= dcnt - DCW'(1);
      if (!trial[NUM_W]) begin
        rem <= trial[NUM_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= {rem[NUM_W-2:0], dvd[NUM_W-1]};
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
    if (cmd.div_done) cost <= cost_now;
    if (cmd.res_ok) begin
      res.status <= (item.req_type == REQ_DISPATCH) ? (grant_ok ? ST_OK : ST_EMPTY)
                                                    : (ins_full ? ST_FULL : ST_OK);
      res.granted <= item.req_type == REQ_DISPATCH && grant_ok;
      res.granted_context <= (item.req_type == REQ_DISPATCH && grant_ok)
                             ? 4'(cur) : 4'd0;
      res.granted_is_write <= item.req_type == REQ_DISPATCH && grant_ok && grant_w;
      res.charge <= (item.req_type == REQ_DISPATCH && grant_ok)
                    ? cost[CHARGE_W-1:0] : '0;
      res.busy_contexts <= BUSY_W'(busy_count);
    end
  end
endmodule
`default_nettype wire

[design/virtual_time_fair_io_arbiter.sv]
// top level of the virtual-time fair arbiter
//
// usage: one input beat (req_type, context_id, is_write) on in_valid/in_stall
// gives exactly one result beat on out_valid/out_stall. an insert queues a
// direction on its context fifo; a dispatch grants the busy context with the
// least virtual time (oldest stamp on a tie) and charges it.
// path to the result: an insert without join (also when full) goes straight
// to it, one with join scans all contexts to refresh the minimum; a dispatch
// scans all contexts, and if one is busy charges it, running the bit-serial
// cost divider for a write, then scans again for the minimum. the next beat
// is taken once the block is back in idle after the result is loaded.
// configuration beats (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken
// at any cycle and must only be issued while the block is idle.
// reset (rst, synchronous) clears all context state, sets both scales to one.
// while the receiver stalls, the result holds; one more input is still taken.
`timescale 1ns / 1ps
`default_nettype none
module virtual_time_fair_io_arbiter #(
  parameter int NUM_CONTEXTS = vtfa_pkg::NUM_CONTEXTS_DEF,
  parameter int FIFO_DEPTH = vtfa_pkg::FIFO_DEPTH_DEF,
  parameter int COST_SHIFT = vtfa_pkg::COST_SHIFT_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vtfa_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vtfa_pkg::out_item_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [vtfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vtfa_pkg::SCALE_W-1:0]   cfg_data
);
  import vtfa_pkg::*;
  cmd_t  cmd;
  stat_t st;
  assign cfg_ready = 1'b1;

  vtfa_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .st(st), .cmd(cmd)
  );

  vtfa_dp #(.NUM_CONTEXTS(NUM_CONTEXTS), .FIFO_DEPTH(FIFO_DEPTH),
            .COST_SHIFT(COST_SHIFT)) u_dp (
    .clk(clk), .rst(rst), .in_data(in_data), .cfg_valid(cfg_valid && cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .cmd(cmd), .st(st),
    .out_data(out_data)
  );
endmodule
`default_nettype wire
